[rtl/block_buffer_cache_tags_unit_defines.svh]
// assertion macros for the buffer cache tag unit
// used by files that carry concurrent checks; no other dependencies
`ifndef BLOCK_BUFFER_CACHE_TAGS_UNIT_DEFINES_SVH
`define BLOCK_BUFFER_CACHE_TAGS_UNIT_DEFINES_SVH

// same-cycle implication under active-low reset
`define BBCT_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("bbct check failed");

// next-cycle implication under active-low reset
`define BBCT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("bbct check failed");

`endif

[rtl/bbct_pkg.sv]
// shared types and constants of the buffer cache tag unit
// no dependencies
`default_nettype none

package bbct_pkg;

  localparam int unsigned SLOTS_DEF = 64;
  localparam logic [31:0] UNUSED_TAG = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_FREE   = 2'd1,
    ST_UNREF_REL = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_e;

  localparam logic ACT_LOOKUP  = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  // per-field write enables of the slot memory
  typedef struct packed {
    logic tag;
    logic cnt;
    logic nxt;
    logic prv;
  } bbct_we_t;

endpackage

`default_nettype wire

[rtl/bbct_if.sv]
// request and result channel interfaces of the buffer cache tag unit
// no dependencies
`default_nettype none

interface bbct_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [7:0]  device_id;
  logic [31:0] block_number;
  logic [5:0]  slot_index;
  modport source (output valid, action, device_id, block_number, slot_index, input ready);
  modport sink   (input valid, action, device_id, block_number, slot_index, output ready);
endinterface

interface bbct_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] slot;
  logic       hit;
  logic       fill_needed;
  logic [1:0] status;
  modport source (output valid, slot, hit, fill_needed, status, input ready);
  modport sink   (input valid, slot, hit, fill_needed, status, output ready);
endinterface

`default_nettype wire

[rtl/bbct_mem.sv]
// slot memory: tags, reference count and links, one write and one read port
// depends on bbct_pkg
`default_nettype none

module bbct_mem import bbct_pkg::*; #(
  parameter int unsigned SLOTS = SLOTS_DEF,
  parameter int unsigned AW    = $clog2(SLOTS),
  parameter int unsigned LW    = $clog2(SLOTS + 1)
) (
  input  wire logic          clk_i,
  input  wire bbct_we_t      we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [7:0]    wdev_i,
  input  wire logic [31:0]   wblk_i,
  input  wire logic [7:0]    wcnt_i,
  input  wire logic [LW-1:0] wnxt_i,
  input  wire logic [LW-1:0] wprv_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic [7:0]         rdev_o,
  output logic [31:0]        rblk_o,
  output logic [7:0]         rcnt_o,
  output logic [LW-1:0]      rnxt_o,
  output logic [LW-1:0]      rprv_o
);

  logic [7:0]    dev_mem [SLOTS];
  logic [31:0]   blk_mem [SLOTS];
  logic [7:0]    cnt_mem [SLOTS];
  logic [LW-1:0] nxt_mem [SLOTS];
  logic [LW-1:0] prv_mem [SLOTS];

  always_ff @(posedge clk_i) begin
    if (we_i.tag) begin
      dev_mem[waddr_i] <= wdev_i;
      blk_mem[waddr_i] <= wblk_i;
    end
    if (we_i.cnt) cnt_mem[waddr_i] <= wcnt_i;
    if (we_i.nxt) nxt_mem[waddr_i] <= wnxt_i;
    if (we_i.prv) prv_mem[waddr_i] <= wprv_i;
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdev_o <= dev_mem[raddr_i];
      rblk_o <= blk_mem[raddr_i];
      rcnt_o <= cnt_mem[raddr_i];
      rnxt_o <= nxt_mem[raddr_i];
      rprv_o <= prv_mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

[rtl/block_buffer_cache_tags_unit.sv]
// Tag and replacement engine of a disk block buffer cache.
// Request channel in_i carries a lookup (device, block) or a release (slot).
// Result channel out_o returns one beat per request: slot, hit, fill_needed
// and a status code (ok, no free slot, unreferenced release, overflow).
// All slot state lives in one single-port-read memory with a registered read;
// a lookup walks the linked slot order one slot per cycle, first along the
// next links for a tag match, then along the prev links for a free slot.
// A lookup's run time is set by the two list walks through the memory read
// port; a release that drops the count to zero also relinks the slot in four
// steps, each writing one memory entry or a head pointer.
// One request is worked on at a time; in_i.ready is high only when idle.
// Results sit in an output register, so the next request is taken while a
// finished result still waits for out_o.ready; a stalled receiver holds the
// beat and, once a second result is ready, stops further requests.
// After reset a clearing pass writes the initial tags, counts and link order
// into every slot of the memory; no request is taken during it.
`default_nettype none
`include "block_buffer_cache_tags_unit_defines.svh"

module block_buffer_cache_tags_unit import bbct_pkg::*; #(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  bbct_in_if.sink     in_i,
  bbct_out_if.source  out_o
);

  localparam int unsigned AW = $clog2(SLOTS);
  localparam int unsigned LW = $clog2(SLOTS + 1);
  localparam logic [LW-1:0] HEAD = LW'(SLOTS);

  typedef enum logic [9:0] {
    S_CLR   = 10'b00_0000_0001,
    S_IDLE  = 10'b00_0000_0010,
    S_HSCAN = 10'b00_0000_0100,
    S_FSCAN = 10'b00_0000_1000,
    S_RREAD = 10'b00_0001_0000,
    S_RUNLN = 10'b00_0010_0000,
    S_RUNLP = 10'b00_0100_0000,
    S_RLINK = 10'b00_1000_0000,
    S_RTAIL = 10'b01_0000_0000,
    S_DONE  = 10'b10_0000_0000
  } state_e;

  state_e        state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [LW-1:0] cur_q, cur_d, k_q, k_d, n_q, n_d, p_q, p_d;
  logic [LW-1:0] hnext_q, hnext_d, hprev_q, hprev_d;
  logic [7:0]    dev_q, dev_d;
  logic [31:0]   blk_q, blk_d;
  logic [5:0]    rslot_q, rslot_d;
  logic          rhit_q, rhit_d, rfill_q, rfill_d;
  status_e       rstat_q, rstat_d;
  logic          ovalid_q, ovalid_d;
  logic [5:0]    oslot_q;
  logic          ohit_q, ofill_q;
  status_e       ostat_q;
  logic          oload;

  bbct_we_t      we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdev, wcnt, rdev, rcnt;
  logic [31:0]   wblk, rblk;
  logic [LW-1:0] wnxt, wprv, rnxt, rprv;
  logic          re, match;

  bbct_mem #(.SLOTS(SLOTS), .AW(AW), .LW(LW)) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdev_i  (wdev),
    .wblk_i  (wblk),
    .wcnt_i  (wcnt),
    .wnxt_i  (wnxt),
    .wprv_i  (wprv),
    .re_i    (re),
    .raddr_i (raddr),
    .rdev_o  (rdev),
    .rblk_o  (rblk),
    .rcnt_o  (rcnt),
    .rnxt_o  (rnxt),
    .rprv_o  (rprv)
  );

  assign match = (rblk != UNUSED_TAG) && (rblk == blk_q) && (rdev == dev_q);
  assign in_i.ready = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    cur_d   = cur_q;
    k_d     = k_q;
    n_d     = n_q;
    p_d     = p_q;
    hnext_d = hnext_q;
    hprev_d = hprev_q;
    dev_d   = dev_q;
    blk_d   = blk_q;
    rslot_d = rslot_q;
    rhit_d  = rhit_q;
    rfill_d = rfill_q;
    rstat_d = rstat_q;
    we      = '0;
    waddr   = cur_q[AW-1:0];
    wdev    = dev_q;
    wblk    = blk_q;
    wcnt    = rcnt;
    wnxt    = HEAD;
    wprv    = HEAD;
    re      = 1'b0;
    raddr   = cur_q[AW-1:0];
    oload   = 1'b0;

    case (state_q)
      S_CLR: begin
        we    = '{tag: 1'b1, cnt: 1'b1, nxt: 1'b1, prv: 1'b1};
        waddr = clr_q;
        wdev  = '0;
        wblk  = UNUSED_TAG;
        wcnt  = '0;
        wnxt  = (clr_q == '0) ? HEAD : LW'(clr_q) - LW'(1);
        wprv  = (LW'(clr_q) == LW'(SLOTS - 1)) ? HEAD : LW'(clr_q) + LW'(1);
        clr_d = clr_q + AW'(1);
        if (LW'(clr_q) == LW'(SLOTS - 1)) state_d = S_IDLE;
      end

      S_IDLE: begin
        if (in_i.valid) begin
          dev_d   = in_i.device_id;
          blk_d   = in_i.block_number;
          rhit_d  = 1'b0;
          rfill_d = 1'b0;
          rstat_d = ST_OK;
          if (in_i.action == ACT_LOOKUP) begin
            k_d = LW'(1);
            if (hnext_q != HEAD) begin
              cur_d   = hnext_q;
              re      = 1'b1;
              raddr   = hnext_q[AW-1:0];
              state_d = S_HSCAN;
            end else if (hprev_q != HEAD) begin
              cur_d   = hprev_q;
              re      = 1'b1;
              raddr   = hprev_q[AW-1:0];
              state_d = S_FSCAN;
            end else begin
              rslot_d = '0;
              rstat_d = ST_NO_FREE;
              state_d = S_DONE;
            end
          end else begin
            rslot_d = in_i.slot_index;
            if (int'(in_i.slot_index) >= SLOTS) begin
              rstat_d = ST_UNREF_REL;
              state_d = S_DONE;
            end else begin
              cur_d   = LW'(in_i.slot_index);
              re      = 1'b1;
              raddr   = AW'(in_i.slot_index);
              state_d = S_RREAD;
            end
          end
        end
      end

      S_HSCAN: begin
        if (match) begin
          rslot_d = 6'(cur_q);
          rhit_d  = 1'b1;
          if (rcnt == 8'hFF) begin
            rstat_d = ST_OVERFLOW;
          end else begin
            we.cnt = 1'b1;
            wcnt   = rcnt + 8'd1;
          end
          state_d = S_DONE;
        end else if (rnxt != HEAD && k_q != HEAD) begin
          cur_d = rnxt;
          k_d   = k_q + LW'(1);
          re    = 1'b1;
          raddr = rnxt[AW-1:0];
        end else if (hprev_q != HEAD) begin
          // no tag match: walk for a free slot from the reuse end
          cur_d   = hprev_q;
          k_d     = LW'(1);
          re      = 1'b1;
          raddr   = hprev_q[AW-1:0];
          state_d = S_FSCAN;
        end else begin
          rslot_d = '0;
          rstat_d = ST_NO_FREE;
          state_d = S_DONE;
        end
      end

      S_FSCAN: begin
        if (rcnt == '0) begin
          we.tag  = 1'b1;
          we.cnt  = 1'b1;
          wcnt    = 8'd1;
          rslot_d = 6'(cur_q);
          rfill_d = 1'b1;
          state_d = S_DONE;
        end else if (rprv != HEAD && k_q != HEAD) begin
          cur_d = rprv;
          k_d   = k_q + LW'(1);
          re    = 1'b1;
          raddr = rprv[AW-1:0];
        end else begin
          rslot_d = '0;
          rstat_d = ST_NO_FREE;
          state_d = S_DONE;
        end
      end

      S_RREAD: begin
        if (rcnt == '0) begin
          rstat_d = ST_UNREF_REL;
          state_d = S_DONE;
        end else begin
          we.cnt = 1'b1;
          wcnt   = rcnt - 8'd1;
          if (rcnt == 8'd1) begin
            n_d     = rnxt;
            p_d     = rprv;
            state_d = S_RUNLN;
          end else begin
            state_d = S_DONE;
          end
        end
      end

      // unlink: prev of the next neighbour
      S_RUNLN: begin
        if (n_q == HEAD) begin
          hprev_d = p_q;
        end else begin
          we.prv = 1'b1;
          waddr  = n_q[AW-1:0];
          wprv   = p_q;
        end
        state_d = S_RUNLP;
      end

      // unlink: next of the prev neighbour
      S_RUNLP: begin
        if (p_q == HEAD) begin
          hnext_d = n_q;
        end else begin
          we.nxt = 1'b1;
          waddr  = p_q[AW-1:0];
          wnxt   = n_q;
        end
        state_d = S_RLINK;
      end

      // relink the slot after the current tail; tail kept in n
      S_RLINK: begin
        we.nxt  = 1'b1;
        we.prv  = 1'b1;
        wnxt    = HEAD;
        wprv    = hprev_q;
        n_d     = hprev_q;
        hprev_d = cur_q;
        state_d = S_RTAIL;
      end

      S_RTAIL: begin
        if (n_q == HEAD) begin
          hnext_d = cur_q;
        end else begin
          we.nxt = 1'b1;
          waddr  = n_q[AW-1:0];
          wnxt   = cur_q;
        end
        state_d = S_DONE;
      end

      S_DONE: begin
        if (!ovalid_q || out_o.ready) begin
          oload   = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ovalid_d = ovalid_q;
    if (oload) ovalid_d = 1'b1;
    else if (out_o.ready) ovalid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLR;
      clr_q    <= '0;
      hnext_q  <= LW'(SLOTS - 1);
      hprev_q  <= '0;
      ovalid_q <= 1'b0;
      k_q      <= '0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      hnext_q  <= hnext_d;
      hprev_q  <= hprev_d;
      ovalid_q <= ovalid_d;
      k_q      <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    n_q     <= n_d;
    p_q     <= p_d;
    dev_q   <= dev_d;
    blk_q   <= blk_d;
    rslot_q <= rslot_d;
    rhit_q  <= rhit_d;
    rfill_q <= rfill_d;
    rstat_q <= rstat_d;
    if (oload) begin
      oslot_q <= rslot_q;
      ohit_q  <= rhit_q;
      ofill_q <= rfill_q;
      ostat_q <= rstat_q;
    end
  end

  assign out_o.valid       = ovalid_q;
  assign out_o.slot        = oslot_q;
  assign out_o.hit         = ohit_q;
  assign out_o.fill_needed = ofill_q;
  assign out_o.status      = ostat_q;

  `BBCT_ASSERT_NEXT(a_accept_leaves_idle, clk_i, rst_ni, in_i.valid && in_i.ready, state_q != S_IDLE)
  `BBCT_ASSERT_NOW(a_no_write_idle, clk_i, rst_ni, state_q == S_IDLE, we == '0)
  `BBCT_ASSERT_NOW(a_hit_fill_excl, clk_i, rst_ni, ovalid_q, !(ohit_q && ofill_q))
  `BBCT_ASSERT_NOW(a_walk_bound, clk_i, rst_ni, state_q == S_HSCAN || state_q == S_FSCAN, k_q <= HEAD && k_q != '0)

endmodule

`default_nettype wire

[tb/tb.sv]
// testbench of the buffer cache tag unit: lookups and releases are driven on
// the request channel and every result beat is checked against a local model
// depends on bbct_pkg, the channel interfaces in bbct_if.sv and the tag unit
`timescale 1ns / 1ps

module tb;
  import bbct_pkg::*;

  localparam int unsigned NSLOT = SLOTS_DEF;
  localparam int unsigned HEADP = NSLOT;
  localparam int unsigned MAX_CYCLES = 2000000;

  typedef struct packed {
    logic [5:0] slot;
    logic       hit;
    logic       fill;
    status_e    status;
  } result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  bbct_in_if  req_if ();
  bbct_out_if res_if ();

  block_buffer_cache_tags_unit i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_if),
    .out_o (res_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // cache model state
  logic [7:0]  dev_tag [NSLOT];
  logic [31:0] blk_tag [NSLOT];
  logic [7:0]  refs    [NSLOT];
  int unsigned nxt     [NSLOT];
  int unsigned prv     [NSLOT];
  int unsigned head_nxt, head_prv;

  result_t results_due[$];
  int      n_errors = 0;
  int      cycles = 0;
  bit      hold_off = 1'b0;
  bit      rand_stall = 1'b1;

  // known tags for reuse in random lookups
  logic [7:0]  seen_dev[$];
  logic [31:0] seen_blk[$];

  function automatic int unsigned link_next(int unsigned n);
    return n < HEADP ? nxt[n] : head_nxt;
  endfunction

  function automatic int unsigned link_prev(int unsigned n);
    return n < HEADP ? prv[n] : head_prv;
  endfunction

  function automatic void set_next(int unsigned n, int unsigned v);
    if (n < HEADP) nxt[n] = v; else head_nxt = v;
  endfunction

  function automatic void set_prev(int unsigned n, int unsigned v);
    if (n < HEADP) prv[n] = v; else head_prv = v;
  endfunction

  task automatic cache_reset();
    for (int i = 0; i < NSLOT; i++) begin
      dev_tag[i] = '0;
      blk_tag[i] = UNUSED_TAG;
      refs[i] = '0;
      nxt[i] = (i == 0) ? HEADP : i - 1;
      prv[i] = (i == NSLOT - 1) ? HEADP : i + 1;
    end
    head_nxt = NSLOT - 1;
    head_prv = 0;
  endtask

  function automatic result_t cache_access(logic act, logic [7:0] dev, logic [31:0] blk,
                                           logic [5:0] idx);
    result_t r;
    int unsigned cur, n, p, tail;
    bit done;
    r = '{slot: '0, hit: 1'b0, fill: 1'b0, status: ST_OK};
    done = 1'b0;
    if (act == ACT_LOOKUP) begin
      cur = head_nxt;
      for (int k = 0; k < NSLOT && cur < HEADP; k++) begin
        if (blk_tag[cur] != UNUSED_TAG && blk_tag[cur] == blk && dev_tag[cur] == dev) begin
          r.slot = 6'(cur);
          r.hit = 1'b1;
          if (refs[cur] == 8'hFF) r.status = ST_OVERFLOW;
          else refs[cur]++;
          done = 1'b1;
          break;
        end
        cur = nxt[cur];
      end
      if (!done) begin
        cur = head_prv;
        for (int k = 0; k < NSLOT && cur < HEADP; k++) begin
          if (refs[cur] == 0) begin
            dev_tag[cur] = dev;
            blk_tag[cur] = blk;
            refs[cur] = 8'd1;
            r.slot = 6'(cur);
            r.fill = 1'b1;
            done = 1'b1;
            break;
          end
          cur = prv[cur];
        end
        if (!done) r.status = ST_NO_FREE;
      end
    end else begin
      r.slot = idx;
      if (idx >= NSLOT || refs[idx] == 0) begin
        r.status = ST_UNREF_REL;
      end else begin
        refs[idx]--;
        if (refs[idx] == 0) begin
          // relink on the head's prev side
          n = link_next(idx);
          p = link_prev(idx);
          set_prev(n, p);
          set_next(p, n);
          tail = head_prv;
          nxt[idx] = HEADP;
          prv[idx] = tail;
          set_next(tail, idx);
          head_prv = idx;
        end
      end
    end
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    n_errors++;
    $display("error at %0t: %s got %0h expected %0h", $realtime, what, got, want);
  endtask

  // sends one request beat, after a random gap while rand_stall is set, and records
  // the expectation; valid stays up after the accepting edge unless a gap follows
  task automatic send_req(logic act, logic [7:0] dev, logic [31:0] blk, logic [5:0] idx);
    int gap;
    gap = rand_stall ? $urandom_range(0, 10) : 0;
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.action       <= act;
    req_if.device_id    <= dev;
    req_if.block_number <= blk;
    req_if.slot_index   <= idx;
    do @(posedge clk_i); while (!req_if.ready);
    results_due.push_back(cache_access(act, dev, blk, idx));
    if (act == ACT_LOOKUP && blk != UNUSED_TAG) begin
      seen_dev.push_back(dev);
      seen_blk.push_back(blk);
    end
  endtask

  task automatic lookup(logic [7:0] dev, logic [31:0] blk);
    send_req(ACT_LOOKUP, dev, blk, 6'($urandom));
  endtask

  task automatic release_slot(logic [5:0] idx);
    send_req(ACT_RELEASE, 8'($urandom), $urandom, idx);
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (2 * NSLOT + 10) @(posedge clk_i);
  endtask

  // receiver side: random stalls, or a long hold while hold_off is set
  initial begin
    int wait_n;
    res_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        res_if.ready <= 1'b0;
      end else if (res_if.ready && res_if.valid) begin
        wait_n = rand_stall ? $urandom_range(0, 10) : 0;
        if (wait_n != 0) res_if.ready <= 1'b0;
        else res_if.ready <= 1'b1;
        repeat (wait_n) @(posedge clk_i);
        if (wait_n != 0) res_if.ready <= 1'b1;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (results_due.size() == 0) begin
        report("unexpected beat, slot", 32'(res_if.slot), 0);
      end else begin
        want = results_due.pop_front();
        if (res_if.slot !== want.slot)
          report("slot", 32'(res_if.slot), 32'(want.slot));
        if (res_if.hit !== want.hit)
          report("hit", 32'(res_if.hit), 32'(want.hit));
        if (res_if.fill_needed !== want.fill)
          report("fill_needed", 32'(res_if.fill_needed), 32'(want.fill));
        if (res_if.status !== want.status)
          report("status", 32'(res_if.status), 32'(want.status));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic test_directed();
    lookup(8'h00, 32'h0000_0000);
    lookup(8'hFF, 32'hFFFF_FFFE);
    lookup(8'h00, 32'h0000_0000);             // hit
    lookup(8'h12, UNUSED_TAG);                // unused marker always misses
    lookup(8'h12, UNUSED_TAG);
    release_slot(6'd63);
    release_slot(6'd63);
    release_slot(6'd63);                      // already unreferenced
    release_slot(6'd20);
    lookup(8'hA5, 32'h5A5A_A5A5);
    release_slot(6'd0);
    lookup(8'h00, 32'h0000_0000);
    lookup(8'hFF, 32'hFFFF_FFFE);
    release_slot(6'd62);
    release_slot(6'd62);
    lookup(8'h7E, 32'h8000_0001);
  endtask

  // count saturation: hammer one tag past 255
  task automatic test_overflow();
    for (int i = 0; i < 258; i++) lookup(8'h3C, 32'hC0FF_EE00);
  endtask

  // fill every slot so further misses find no free slot
  task automatic test_full();
    rand_stall = 1'b0;
    for (int i = 0; i < NSLOT + 3; i++) lookup(8'hE0, 32'h0001_0000 + i);
    for (int i = 0; i < NSLOT; i++) release_slot(6'(i));
    rand_stall = 1'b1;
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 6; i++) lookup(8'($urandom), $urandom_range(0, 40));
    join
  endtask

  task automatic test_random(int count);
    int pick, j;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) rand_stall = 1'b0;
      if (i == count / 2 + 100) rand_stall = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 40 && seen_blk.size() != 0) begin
        j = $urandom_range(0, seen_blk.size() - 1);
        lookup(seen_dev[j], seen_blk[j]);
      end else if (pick < 55) begin
        lookup(8'($urandom_range(0, 3)), $urandom_range(0, 200));
      end else if (pick < 60) begin
        lookup(8'($urandom), (pick == 55) ? UNUSED_TAG : $urandom);
      end else begin
        release_slot(6'($urandom));
      end
    end
  endtask

  initial begin
    req_if.valid        <= 1'b0;
    req_if.action       <= ACT_LOOKUP;
    req_if.device_id    <= '0;
    req_if.block_number <= '0;
    req_if.slot_index   <= '0;
    cache_reset();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_overflow();
    test_full();
    test_backpressure();
    test_random(1300);
    wait_drained();
    if (n_errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/bbct_pkg.sv
rtl/bbct_if.sv
rtl/bbct_mem.sv
rtl/block_buffer_cache_tags_unit.sv
tb/tb.sv
